### src/fraction_arith_gcd_reduce_defines.svh
// Assertion macros shared by the fraction reducer modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FRACTION_ARITH_GCD_REDUCE_DEFINES_SVH
`define FRACTION_ARITH_GCD_REDUCE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FGCD_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FGCD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fgcd_pkg.sv
`timescale 1ns / 1ps

package fgcd_pkg;

    // Default width of each operand field.
    localparam int unsigned DEF_OPERAND_WIDTH = 16;

    // Entries in the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Queue entry: status, raw numerator, raw denominator.
    localparam int unsigned DEF_QUEUE_WIDTH = 2 + (2 * DEF_OPERAND_WIDTH + 1)
                                            + (2 * DEF_OPERAND_WIDTH);

    // Operation codes.
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_UNDEF = 2'd2
    } t_status;

endpackage

### src/fgcd_front.sv
`timescale 1ns / 1ps
`include "fraction_arith_gcd_reduce_defines.svh"

module fgcd_front #(
    parameter int unsigned OPERAND_WIDTH = fgcd_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_cmd,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                            o_push,
    input  logic                            i_push_ready,
    output fgcd_pkg::t_status               o_push_status,
    output logic [2*OPERAND_WIDTH:0]        o_push_num,
    output logic [2*OPERAND_WIDTH-1:0]      o_push_den
);
    import fgcd_pkg::*;

    localparam int unsigned PW = 2 * OPERAND_WIDTH;
    localparam int unsigned NW = PW + 1;

    t_cmd                          w_cmd;
    logic signed [OPERAND_WIDTH-1:0] w_b_for_num;
    logic signed [OPERAND_WIDTH-1:0] w_b_for_den;
    logic signed [PW-1:0]          n_p0;
    logic signed [PW-1:0]          n_p1;
    logic signed [PW-1:0]          n_pd;
    logic signed [NW-1:0]          w_num;
    logic signed [NW-1:0]          w_p0;
    logic signed [NW-1:0]          w_p1;

    logic                          r_pv;
    t_cmd                          r_cmd;
    logic signed [PW-1:0]          r_p0;
    logic signed [PW-1:0]          r_p1;
    logic signed [PW-1:0]          r_pd;

    // Operand selection and the three cross products.
    always_comb begin
        w_cmd       = t_cmd'(i_cmd);
        w_b_for_num = (w_cmd == CMD_MUL) ? i_b_num : i_b_den;
        w_b_for_den = (w_cmd == CMD_DIV) ? i_b_num : i_b_den;
        n_p0        = PW'(i_a_num) * PW'(w_b_for_num);
        n_p1        = PW'(i_a_den) * PW'(i_b_num);
        n_pd        = PW'(i_a_den) * PW'(w_b_for_den);
    end

    // The product stage advances whenever the queue can take its contents.
    assign o_ready = !r_pv || i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (o_ready) begin
            r_pv <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_cmd <= w_cmd;
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_pd  <= n_pd;
        end
    end

    // Combine the cross terms and classify the raw fraction.
    always_comb begin
        w_p0 = NW'(r_p0);
        w_p1 = NW'(r_p1);
        unique case (r_cmd)
            CMD_ADD:          w_num = w_p0 + w_p1;
            CMD_SUB:          w_num = w_p0 - w_p1;
            CMD_MUL, CMD_DIV: w_num = w_p0;
        endcase
        priority if (w_num == '0) begin
            o_push_status = ST_ZERO;
        end else if (r_pd == '0) begin
            o_push_status = ST_UNDEF;
        end else begin
            o_push_status = ST_OK;
        end
    end

    assign o_push     = r_pv;
    assign o_push_num = w_num;
    assign o_push_den = r_pd;

    `FGCD_ASSERT_NEXT(a_front_hold, r_pv && !i_push_ready, r_pv && $stable(r_p0), "front product changed while stalled")

endmodule

### src/fgcd_queue.sv
`timescale 1ns / 1ps
`include "fraction_arith_gcd_reduce_defines.svh"

module fgcd_queue #(
    parameter int unsigned WIDTH = fgcd_pkg::DEF_QUEUE_WIDTH,
    parameter int unsigned DEPTH = fgcd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    import fgcd_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_ent [DEPTH];
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;
    logic [CW-1:0]    n_wr_idx;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_data       = r_ent[0];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_valid;
    assign n_wr_idx     = w_pop ? (r_count - CW'(1)) : r_count;

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_push && !w_pop) begin
            r_count <= r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Entries shift toward the head on a pop; a push lands behind the last one.
    for (genvar g = 0; g < DEPTH; g++) begin : g_ent
        if (g < DEPTH - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (w_push && (n_wr_idx == CW'(g))) begin
                    r_ent[g] <= i_data;
                end else if (w_pop) begin
                    r_ent[g] <= r_ent[g+1];
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (w_push && (n_wr_idx == CW'(g))) begin
                    r_ent[g] <= i_data;
                end
            end
        end
    end

    `FGCD_ASSERT_IMPL(a_queue_bound, 1'b1, r_count <= CW'(DEPTH), "queue count above depth")

endmodule

### src/fgcd_back.sv
`timescale 1ns / 1ps
`include "fraction_arith_gcd_reduce_defines.svh"

module fgcd_back #(
    parameter int unsigned OPERAND_WIDTH = fgcd_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_q_valid,
    output logic                                    o_q_pop,
    input  logic [2+(4*OPERAND_WIDTH+1)-1:0]        i_q_data,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output fgcd_pkg::t_status                       o_status,
    output logic [2*OPERAND_WIDTH:0]                o_res_num,
    output logic [2*OPERAND_WIDTH-1:0]              o_res_den
);
    import fgcd_pkg::*;

    localparam int unsigned PW = 2 * OPERAND_WIDTH;
    localparam int unsigned NW = PW + 1;
    localparam int unsigned KW = $clog2(NW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_SHRINK,
        S_DIV,
        S_FIN
    } t_state;

    t_state           r_state;
    t_status          r_status;
    logic [NW-1:0]    r_a;
    logic [NW-1:0]    r_b;
    logic [NW-1:0]    r_d;
    logic             r_par;
    logic             r_neg;
    logic [NW-1:0]    r_qn;
    logic [NW-1:0]    r_qd;
    logic [NW-1:0]    r_rn;
    logic [NW-1:0]    r_rd;
    logic [KW-1:0]    r_cnt;
    logic             r_out_valid;
    t_status          r_out_status;
    logic [NW-1:0]    r_out_num;
    logic [PW-1:0]    r_out_den;

    t_status          w_q_status;
    logic [NW-1:0]    w_q_num;
    logic [PW-1:0]    w_q_den;
    logic [NW-1:0]    w_den_ext;
    logic [NW-1:0]    n_num_mag;
    logic [NW-1:0]    n_den_mag;
    logic [NW:0]      w_d2;
    logic             w_grow;
    logic [NW-1:0]    n_a_rem;
    logic [NW:0]      w_rn_sh;
    logic [NW:0]      w_rd_sh;
    logic             w_rn_ge;
    logic             w_rd_ge;
    logic [NW:0]      n_rn;
    logic [NW:0]      n_rd;
    logic [NW-1:0]    n_out_num;
    logic [NW-1:0]    n_out_den;
    logic             w_out_free;

    // Unpack the queue entry and take magnitudes; the signs only decide the
    // combined sign, which one reduced part then carries.
    always_comb begin
        w_q_status = t_status'(i_q_data[NW+PW+1:NW+PW]);
        w_q_num    = i_q_data[NW+PW-1:PW];
        w_q_den    = i_q_data[PW-1:0];
        w_den_ext  = {w_q_den[PW-1], w_q_den};
        n_num_mag  = w_q_num[NW-1] ? (-w_q_num) : w_q_num;
        n_den_mag  = w_den_ext[NW-1] ? (-w_den_ext) : w_den_ext;
    end

    // Remainder unit: scale the divisor up while it fits, then subtract
    // and scale back down one position per cycle.
    always_comb begin
        w_d2    = {r_d, 1'b0};
        w_grow  = !r_d[NW-1] && (w_d2 <= {1'b0, r_a});
        n_a_rem = (r_d <= r_a) ? (r_a - r_d) : r_a;
    end

    // Restoring divider, one quotient bit per cycle for both parts.
    always_comb begin
        w_rn_sh = {r_rn, r_qn[NW-1]};
        w_rd_sh = {r_rd, r_qd[NW-1]};
        w_rn_ge = (w_rn_sh >= {1'b0, r_a});
        w_rd_ge = (w_rd_sh >= {1'b0, r_a});
        n_rn    = w_rn_ge ? (w_rn_sh - {1'b0, r_a}) : w_rn_sh;
        n_rd    = w_rd_ge ? (w_rd_sh - {1'b0, r_a}) : w_rd_sh;
    end

    // The divisor's sign follows the numerator on an even step count and
    // the denominator on an odd one, so the other part takes the sign.
    always_comb begin
        n_out_num = (r_par && r_neg) ? (-r_qn) : r_qn;
        n_out_den = (!r_par && r_neg) ? (-r_qd) : r_qd;
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign o_q_pop    = (r_state == S_IDLE);

    // Sequencer with its datapath registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_status <= w_q_status;
                        r_neg    <= (w_q_status == ST_OK)
                                    && (w_q_num[NW-1] ^ w_q_den[PW-1]);
                        r_par    <= 1'b0;
                        r_a      <= n_num_mag;
                        r_b      <= n_den_mag;
                        r_d      <= n_den_mag;
                        if (w_q_status == ST_OK) begin
                            r_qn    <= n_num_mag;
                            r_qd    <= n_den_mag;
                            r_state <= S_GROW;
                        end else begin
                            r_qn    <= '0;
                            r_qd    <= (w_q_status == ST_ZERO) ? NW'(1) : '0;
                            r_state <= S_FIN;
                        end
                    end
                end
                S_GROW: begin
                    if (w_grow) begin
                        r_d <= w_d2[NW-1:0];
                    end else begin
                        r_state <= S_SHRINK;
                    end
                end
                S_SHRINK: begin
                    if (r_d == r_b) begin
                        // One remainder finished: shift the pair along.
                        r_a   <= r_b;
                        r_b   <= n_a_rem;
                        r_d   <= n_a_rem;
                        r_par <= !r_par;
                        if (n_a_rem == '0) begin
                            r_rn    <= '0;
                            r_rd    <= '0;
                            r_cnt   <= KW'(NW - 1);
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_GROW;
                        end
                    end else begin
                        r_a <= n_a_rem;
                        r_d <= {1'b0, r_d[NW-1:1]};
                    end
                end
                S_DIV: begin
                    r_rn <= n_rn[NW-1:0];
                    r_rd <= n_rd[NW-1:0];
                    r_qn <= {r_qn[NW-2:0], w_rn_ge};
                    r_qd <= {r_qd[NW-2:0], w_rd_ge};
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt - KW'(1);
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_status <= r_status;
                        r_out_num    <= n_out_num;
                        r_out_den    <= n_out_den[PW-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_out_status;
    assign o_res_num = r_out_num;
    assign o_res_den = r_out_den;

    `FGCD_ASSERT_IMPL(a_div_nonzero, r_state == S_DIV, r_a != '0,
                      "divider started with a zero divisor")
    `FGCD_ASSERT_IMPL(a_zero_form, o_valid && (o_status == ST_ZERO),
                      (o_res_num == '0) && (o_res_den == PW'(1)),
                      "zero result is not 0/1")
    `FGCD_ASSERT_IMPL(a_undef_form, o_valid && (o_status == ST_UNDEF),
                      (o_res_num == '0) && (o_res_den == '0),
                      "undefined result is not 0/0")

endmodule

### src/fraction_arith_gcd_reduce.sv
// Flow: the product and classify stage registers each request into the queue, the back end pops it,
// runs Euclid steps on the remainder unit, then the divider, and loads the output register;
// zero and undefined results skip the remainder unit and divider and go straight to the output.
// The back end works on one item at a time and pops the next only once it is idle again;
// the queue holds further items meanwhile.
// Reset: synchronous, active low; empties the queue and drops the output valid.
`timescale 1ns / 1ps

module fraction_arith_gcd_reduce #(
    parameter int unsigned OPERAND_WIDTH = fgcd_pkg::DEF_OPERAND_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_cmd,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_status,
    output logic signed [2*OPERAND_WIDTH:0] o_res_num,
    output logic signed [2*OPERAND_WIDTH-1:0] o_res_den
);
    import fgcd_pkg::*;

    localparam int unsigned PW = 2 * OPERAND_WIDTH;
    localparam int unsigned NW = PW + 1;
    localparam int unsigned QW = 2 + NW + PW;

    logic          w_push;
    logic          w_push_ready;
    t_status       w_push_status;
    logic [NW-1:0] w_push_num;
    logic [PW-1:0] w_push_den;
    logic          w_q_valid;
    logic          w_q_pop;
    logic [QW-1:0] w_q_data;
    t_status       w_status;
    logic [NW-1:0] w_res_num;
    logic [PW-1:0] w_res_den;

    // Front: cross products and classification.
    fgcd_front #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_cmd         (i_cmd),
        .i_a_num       (i_a_num),
        .i_a_den       (i_a_den),
        .i_b_num       (i_b_num),
        .i_b_den       (i_b_den),
        .o_push        (w_push),
        .i_push_ready  (w_push_ready),
        .o_push_status (w_push_status),
        .o_push_num    (w_push_num),
        .o_push_den    (w_push_den)
    );

    // Short queue between the classifier and the reduction engine.
    fgcd_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_data       ({w_push_status, w_push_num, w_push_den}),
        .o_valid      (w_q_valid),
        .i_pop        (w_q_pop),
        .o_data       (w_q_data)
    );

    // Back: Euclid reduction and exact division.
    fgcd_back #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_data  (w_q_data),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_status  (w_status),
        .o_res_num (w_res_num),
        .o_res_den (w_res_den)
    );

    assign o_status  = w_status;
    assign o_res_num = w_res_num;
    assign o_res_den = w_res_den;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import fgcd_pkg::*;

    localparam int unsigned W = DEF_OPERAND_WIDTH;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned MAX_REPORTS = 10;
    localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

    typedef struct {
        t_status                 status;
        logic signed [2*W:0]     num;
        logic signed [2*W-1:0]   den;
    } t_fraction_result;

    // Keeps the reduced fractions still owed by the block, oldest first.
    class fraction_checker;
        t_fraction_result owed[$];
        int unsigned      bad_count;

        // Cross-multiplies, then divides both parts by Euclid's divisor.
        function t_fraction_result reduce_fraction(t_cmd op, logic signed [W-1:0] an,
                                                   logic signed [W-1:0] ad,
                                                   logic signed [W-1:0] bn,
                                                   logic signed [W-1:0] bd);
            longint la, lad, lb, lbd, n, d, x, y, r;
            t_fraction_result res;
            la = longint'(an);
            lad = longint'(ad);
            lb = longint'(bn);
            lbd = longint'(bd);
            case (op)
                CMD_ADD: begin
                    n = la * lbd + lad * lb;
                    d = lad * lbd;
                end
                CMD_SUB: begin
                    n = la * lbd - lad * lb;
                    d = lad * lbd;
                end
                CMD_MUL: begin
                    n = la * lb;
                    d = lad * lbd;
                end
                default: begin
                    n = la * lbd;
                    d = lad * lb;
                end
            endcase
            // A zero numerator wins even over a zero denominator.
            if (n == 0) begin
                res.status = ST_ZERO;
                res.num = '0;
                res.den = 1;
            end else if (d == 0) begin
                res.status = ST_UNDEF;
                res.num = '0;
                res.den = '0;
            end else begin
                // Truncating remainder, so the divisor may come out negative.
                x = n;
                y = d;
                while (y != 0) begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                res.status = ST_OK;
                res.num = (2*W+1)'(n / x);
                res.den = (2*W)'(d / x);
            end
            return res;
        endfunction

        function void note_request(t_cmd op, logic signed [W-1:0] an, logic signed [W-1:0] ad,
                                   logic signed [W-1:0] bn, logic signed [W-1:0] bd);
            owed.push_back(reduce_fraction(op, an, ad, bn, bd));
        endfunction

        function void check_result(logic [1:0] status, logic signed [2*W:0] num,
                                   logic signed [2*W-1:0] den);
            t_fraction_result want;
            if (owed.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d num %0d den %0d", status, num, den);
                return;
            end
            want = owed.pop_front();
            if (status !== want.status || num !== want.num || den !== want.den) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("wrong result: expected %0d %0d/%0d, got %0d %0d/%0d",
                             want.status, want.num, want.den, status, num, den);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_cmd = CMD_ADD;
    logic signed [W-1:0]     i_a_num = '0;
    logic signed [W-1:0]     i_a_den = '0;
    logic signed [W-1:0]     i_b_num = '0;
    logic signed [W-1:0]     i_b_den = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [1:0]              o_status;
    logic signed [2*W:0]     o_res_num;
    logic signed [2*W-1:0]   o_res_den;

    fraction_checker book = new();
    int unsigned send_idle_pct = 10;
    int unsigned recv_idle_pct = 81;
    int unsigned cycle_count = 0;
    bit          hold_request = 1'b0;
    logic        hold_active = 1'b0;

    fraction_arith_gcd_reduce #(.OPERAND_WIDTH(W)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status   (o_status),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("fraction_arith_gcd_reduce: mismatch");
            $finish;
        end
    end

    // Receiver: random backpressure, or full backpressure during a long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_active) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long hold-off on the result side so that the block backs up into its input.
    initial begin
        wait (hold_request);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Check every result taken from the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.check_result(o_status, o_res_num, o_res_den);
    end

    // Offer one request, idling first at random, and wait until it is taken.
    task automatic offer(input t_cmd op, input logic signed [W-1:0] an,
                         input logic signed [W-1:0] ad, input logic signed [W-1:0] bn,
                         input logic signed [W-1:0] bd);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_cmd <= op;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_request(op, an, ad, bn, bd);
    endtask

    // Operand mix: zeros, extremes, small values, values with common factors, full range.
    function automatic logic signed [W-1:0] pick_operand();
        int f;
        case ($urandom_range(9))
            0: return '0;
            1: begin
                case ($urandom_range(3))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return -1;
                    default: return 1;
                endcase
            end
            2, 3, 4: return W'(int'($urandom_range(40)) - 20);
            5, 6: begin
                f = $urandom_range(12) + 1;
                return W'(f * (int'($urandom_range(200)) - 100));
            end
            default: return W'($urandom);
        endcase
    endfunction

    task automatic random_requests(input int unsigned count);
        repeat (count)
            offer(t_cmd'($urandom_range(3)), pick_operand(), pick_operand(),
                  pick_operand(), pick_operand());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: extremes, every operation, zero and undefined results.
        offer(CMD_ADD, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
        offer(CMD_SUB, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
        offer(CMD_MUL, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
        offer(CMD_DIV, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
        offer(CMD_ADD, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
        offer(CMD_MUL, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
        offer(CMD_MUL, 0, 0, 5, 3);
        offer(CMD_DIV, 3, 4, 0, 7);
        offer(CMD_ADD, 1, 0, 2, 5);
        offer(CMD_SUB, 1, 2, 1, 2);
        offer(CMD_MUL, 1, -2, 3, 1);
        offer(CMD_ADD, -3, 6, 0, 1);
        offer(CMD_DIV, MOST_NEG, 1, -1, MOST_NEG);
        offer(CMD_ADD, MOST_NEG, -1, MOST_NEG, -1);
        offer(CMD_MUL, 6, 4, 10, 15);
        offer(CMD_ADD, 1, 1, MOST_POS, MOST_NEG);
        offer(CMD_SUB, MOST_POS, -1, MOST_NEG, 1);
        offer(CMD_DIV, -1, -1, -1, -1);

        // Random requests under three backpressure patterns.
        random_requests(220);
        send_idle_pct = 81;
        recv_idle_pct = 10;
        random_requests(220);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        random_requests(210);
        i_in_valid <= 1'b0;

        // Let the last results come out, then allow for stragglers.
        while (book.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.bad_count == 0 && book.owed.size() == 0) begin
            $display("fraction_arith_gcd_reduce: match");
        end else begin
            $display("fraction_arith_gcd_reduce: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/fgcd_pkg.sv
src/fgcd_front.sv
src/fgcd_queue.sv
src/fgcd_back.sv
src/fraction_arith_gcd_reduce.sv
test/tb.sv
